[src/blmd_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the blue local minimum detector.
package blmd_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int HEIGHT_CAP    = 1024;
	localparam int SIDE_MIN      = 3;
	localparam int PIX_W         = 8;
	localparam int COORD_W       = 10;
	localparam int ROW_W         = $clog2(HEIGHT_CAP);
	localparam int CFG_W         = 11;
	localparam int CFG_IDX_W     = 1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// Candidate position of a window centre and whether it may be tested.
	typedef struct packed {
		logic               test;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} blmd_tag_t;

endpackage

[src/blmd_if.sv]
`timescale 1ns / 1ps
// Stream interfaces: pixel samples in, minimum positions out.
interface blmd_pix_if;
	logic                        valid;
	logic                        ready;
	logic [blmd_pkg::PIX_W-1:0]  blue_sample;

	modport source (output valid, output blue_sample, input ready);
	modport sink   (input valid, input blue_sample, output ready);
endinterface

interface blmd_res_if;
	logic                          valid;
	logic                          ready;
	logic [blmd_pkg::COORD_W-1:0]  min_row;
	logic [blmd_pkg::COORD_W-1:0]  min_col;

	modport source (output valid, output min_row, output min_col, input ready);
	modport sink   (input valid, input min_row, input min_col, output ready);
endinterface

[src/blue_local_minimum_detector_unit.sv]
`timescale 1ns / 1ps
// Top level of the blue-channel 3x3 strict local minimum detector.
//
//  Channel  Dir  Handshake        Payload
//  pix      in   valid / ready    blue_sample[7:0]
//  res      out  valid / ready    min_row[9:0], min_col[9:0]
//  cfg      in   cfg_we           cfg_index, cfg_data[10:0]
//
// One pixel per clock unless a stalled result holds the flow. The line
// stores are read in the transfer cycle and written back as the pixel
// leaves stage s1; the window and the eight compares sit between that stage
// and the result register. A stalled result stops the pipeline only when the
// pixel behind it also yields a result. Reset clears counters, window and
// valids; line store contents stay unknown until written.
module blue_local_minimum_detector_unit #(
	parameter int MAX_WIDTH = blmd_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [blmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [blmd_pkg::CFG_W-1:0]     cfg_data,
	blmd_pix_if.sink                       pix,
	blmd_res_if.source                     res
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = blmd_pkg::PIX_W;

	logic [blmd_pkg::CFG_W-1:0] width_q;
	logic [blmd_pkg::CFG_W-1:0] height_q;

	logic                accept;
	logic [CW-1:0]       addr;
	blmd_pkg::blmd_tag_t tag;

	logic                valid_s1;
	logic [PW-1:0]       sample_s1;
	logic [CW-1:0]       addr_s1;
	blmd_pkg::blmd_tag_t tag_s1;

	logic [PW-1:0] up_rd;
	logic [PW-1:0] mid_rd;
	logic          win_hit;
	logic          hit;
	logic          adv_s1;

	logic                         res_valid_q;
	logic [blmd_pkg::COORD_W-1:0] row_q;
	logic [blmd_pkg::COORD_W-1:0] col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= blmd_pkg::WIDTH_RESET;
			height_q <= blmd_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				blmd_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				blmd_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign hit       = valid_s1 && tag_s1.test && win_hit;
	// Advance unless a new result would overwrite one still waiting.
	assign adv_s1    = valid_s1 && (!hit || !res_valid_q || res.ready);
	assign pix.ready = !valid_s1 || adv_s1;
	assign accept    = pix.valid && pix.ready;

	blmd_pos #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (accept),
		.width_cfg (width_q),
		.height_cfg(height_q),
		.addr      (addr),
		.tag       (tag)
	);

	blmd_ram #(
		.WIDTH(PW),
		.DEPTH(MAX_WIDTH)
	) u_line_upper (
		.clk  (clk),
		.we   (adv_s1),
		.waddr(addr_s1),
		.wdata(mid_rd),
		.re   (accept),
		.raddr(addr),
		.rdata(up_rd)
	);

	blmd_ram #(
		.WIDTH(PW),
		.DEPTH(MAX_WIDTH)
	) u_line_middle (
		.clk  (clk),
		.we   (adv_s1),
		.waddr(addr_s1),
		.wdata(sample_s1),
		.re   (accept),
		.raddr(addr),
		.rdata(mid_rd)
	);

	blmd_win u_win (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (adv_s1),
		.up    (up_rd),
		.mid   (mid_rd),
		.sample(sample_s1),
		.hit   (win_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= pix.blue_sample;
			addr_s1   <= addr;
			tag_s1    <= tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && hit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && hit) begin
			row_q <= tag_s1.row;
			col_q <= tag_s1.col;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.min_row = row_q;
	assign res.min_col = col_q;

endmodule

[src/blmd_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module blmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/blmd_pos.sv]
`timescale 1ns / 1ps
// Raster position counters, size clamping and border qualification.
module blmd_pos #(
	parameter int MAX_WIDTH = blmd_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [blmd_pkg::CFG_W-1:0]    width_cfg,
	input  logic [blmd_pkg::CFG_W-1:0]    height_cfg,
	output logic [$clog2(MAX_WIDTH)-1:0]  addr,
	output blmd_pkg::blmd_tag_t           tag
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int RW = blmd_pkg::ROW_W;
	localparam int HW = blmd_pkg::CFG_W;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [WW-1:0] w_use;
	logic [HW-1:0] h_use;
	logic          col_wrap;
	logic          row_wrap;

	always_comb begin
		if (width_cfg < HW'(blmd_pkg::SIDE_MIN)) begin
			w_use = WW'(blmd_pkg::SIDE_MIN);
		end else if (32'(width_cfg) > MAX_WIDTH) begin
			w_use = WW'(MAX_WIDTH);
		end else begin
			w_use = WW'(width_cfg);
		end
		if (height_cfg < HW'(blmd_pkg::SIDE_MIN)) begin
			h_use = HW'(blmd_pkg::SIDE_MIN);
		end else if (32'(height_cfg) > blmd_pkg::HEIGHT_CAP) begin
			h_use = HW'(blmd_pkg::HEIGHT_CAP);
		end else begin
			h_use = height_cfg;
		end
	end

	assign col_wrap = (WW'(col_q) + WW'(1)) >= w_use;
	assign row_wrap = (HW'(row_q) + HW'(1)) >= h_use;

	assign addr     = col_q;
	// Centre of the window is one row up and one column left of this sample.
	assign tag.test = (row_q >= RW'(2)) && (32'(col_q) >= 2) &&
		(WW'(col_q) < w_use) && (HW'(row_q) < h_use);
	assign tag.row  = blmd_pkg::COORD_W'(row_q - RW'(1));
	assign tag.col  = blmd_pkg::COORD_W'(32'(col_q) - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (adv) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

[src/blmd_win.sv]
`timescale 1ns / 1ps
// 3x3 window cells and the strict minimum test on the shifted window.
module blmd_win (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift,
	input  logic [blmd_pkg::PIX_W-1:0] up,
	input  logic [blmd_pkg::PIX_W-1:0] mid,
	input  logic [blmd_pkg::PIX_W-1:0] sample,
	output logic                       hit
);

	logic [blmd_pkg::PIX_W-1:0] cell_q [9];
	logic [blmd_pkg::PIX_W-1:0] nxt    [9];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nxt[k*3 + 0] = cell_q[k*3 + 1];
			nxt[k*3 + 1] = cell_q[k*3 + 2];
		end
		nxt[2] = up;
		nxt[5] = mid;
		nxt[8] = sample;
	end

	// Test the window as it stands after this shift.
	always_comb begin
		hit = 1'b1;
		for (int k = 0; k < 9; k++) begin
			if (k != 4 && nxt[k] <= nxt[4]) begin
				hit = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				cell_q[k] <= '0;
			end
		end else if (shift) begin
			for (int k = 0; k < 9; k++) begin
				cell_q[k] <= nxt[k];
			end
		end
	end

endmodule

[verif/tb_blue_local_minimum_detector_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the blue-channel 3x3 strict local minimum detector.
module tb_blue_local_minimum_detector_unit;

	localparam int PIX_W         = blmd_pkg::PIX_W;
	localparam int COORD_W       = blmd_pkg::COORD_W;
	localparam int CFG_W         = blmd_pkg::CFG_W;
	localparam int CFG_IDX_W     = blmd_pkg::CFG_IDX_W;
	localparam int MAX_WIDTH_DEF = blmd_pkg::MAX_WIDTH_DEF;
	localparam int HEIGHT_CAP    = blmd_pkg::HEIGHT_CAP;
	localparam int SIDE_MIN      = blmd_pkg::SIDE_MIN;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS = 1023;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} min_pos_t;

	typedef enum int {
		LEVEL_UNIFORM,
		LEVEL_NARROW,
		LEVEL_DIPS
	} level_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	blmd_pix_if pix ();
	blmd_res_if res ();

	blue_local_minimum_detector_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix),
		.res       (res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Window model state: two line stores, the 3x3 cells, raster position and geometry.
	logic [PIX_W-1:0] upper_row_px  [MAX_WIDTH_DEF];
	logic [PIX_W-1:0] middle_row_px [MAX_WIDTH_DEF];
	logic [PIX_W-1:0] window_px     [9];
	int unsigned      col_at;
	int unsigned      row_at;
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;

	min_pos_t    expected_minima[$];
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned stall_left = 0;
	bit          no_idle = 1'b0;

	function automatic int unsigned clamp_side(input logic [CFG_W-1:0] v, input int unsigned hi);
		if (v < SIDE_MIN)
			return SIDE_MIN;
		if (v > hi)
			return hi;
		return 32'(v);
	endfunction

	// Items left until the raster position returns to the frame origin.
	function automatic int unsigned frame_remaining();
		int unsigned w, h, c, r, n;
		w = clamp_side(width_reg, MAX_WIDTH_DEF);
		h = clamp_side(height_reg, HEIGHT_CAP);
		c = col_at;
		r = row_at;
		n = 0;
		do begin
			n++;
			if (c + 1 >= w) begin
				c = 0;
				r = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				c++;
			end
		end while (c != 0 || r != 0);
		return n;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CFG_W-1:0] pick_side();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 2)
			return CFG_W'($urandom_range(0, 2));
		if (roll < 17)
			return CFG_W'($urandom_range(3, 8));
		return CFG_W'($urandom_range(9, 24));
	endfunction

	function automatic logic [PIX_W-1:0] random_level(input level_mode_t mode,
			input logic [PIX_W-1:0] base);
		case (mode)
			LEVEL_NARROW: return base + PIX_W'($urandom_range(0, 2));
			LEVEL_DIPS: begin
				if ($urandom_range(0, 7) == 0)
					return PIX_W'($urandom_range(0, 127));
				return PIX_W'($urandom_range(128, 255));
			end
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic reset_window_model();
		width_reg = blmd_pkg::WIDTH_RESET;
		height_reg = blmd_pkg::HEIGHT_RESET;
		for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
			upper_row_px[i] = '0;
			middle_row_px[i] = '0;
		end
		for (int k = 0; k < 9; k++)
			window_px[k] = '0;
		col_at = 0;
		row_at = 0;
	endtask

	// Advance the window by one pixel and queue the centre if it is a strict minimum.
	task automatic step_window_model(input logic [PIX_W-1:0] level);
		int unsigned      w, h, c, r;
		logic [PIX_W-1:0] up, mid;
		bit               is_min;
		min_pos_t         hit;
		w = clamp_side(width_reg, MAX_WIDTH_DEF);
		h = clamp_side(height_reg, HEIGHT_CAP);
		c = col_at;
		r = row_at;
		up = '0;
		mid = '0;
		if (c < MAX_WIDTH_DEF) begin
			up = upper_row_px[c];
			mid = middle_row_px[c];
			upper_row_px[c] = mid;
			middle_row_px[c] = level;
		end
		for (int k = 0; k < 3; k++) begin
			window_px[k * 3] = window_px[k * 3 + 1];
			window_px[k * 3 + 1] = window_px[k * 3 + 2];
		end
		window_px[2] = up;
		window_px[5] = mid;
		window_px[8] = level;
		is_min = 1'b1;
		for (int k = 0; k < 9; k++)
			if (k != 4 && window_px[k] <= window_px[4])
				is_min = 1'b0;
		if (r >= 2 && c >= 2 && c < w && r < h && is_min) begin
			hit.row = COORD_W'(r - 1);
			hit.col = COORD_W'(c - 1);
			expected_minima = {expected_minima, hit};
		end
		if (c + 1 >= w) begin
			col_at = 0;
			row_at = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_at = c + 1;
		end
	endtask

	// Leaves valid high after the transfer; the next call decides whether to drop it.
	task automatic send_pixel(input logic [PIX_W-1:0] level);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.blue_sample <= level;
		@(posedge clk);
		while (pix.ready !== 1'b1)
			@(posedge clk);
		step_window_model(level);
	endtask

	// Hold the stream until every queued minimum is out and the pipeline has settled.
	task automatic drain_pipeline();
		pix.valid <= 1'b0;
		while (expected_minima.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			blmd_pkg::REG_IMAGE_WIDTH:  width_reg = val;
			blmd_pkg::REG_IMAGE_HEIGHT: height_reg = val;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic finish_frame();
		if (col_at != 0 || row_at != 0)
			repeat (frame_remaining()) send_pixel(PIX_W'($urandom_range(0, 255)));
	endtask

	// Start at the reset size, shrink the width past the current column, then
	// drop the height below the current row.
	task automatic test_reset_geometry();
		logic [PIX_W-1:0] lead [5] = '{8'd100, 8'd120, 8'd140, 8'd160, 8'd180};
		logic [PIX_W-1:0] body [8] = '{8'd90, 8'd5, 8'd60, 8'd70, 8'd50, 8'd40, 8'd30, 8'd20};
		foreach (lead[i])
			send_pixel(lead[i]);
		drain_pipeline();
		write_reg(blmd_pkg::REG_IMAGE_WIDTH, 11'd4);
		send_pixel(8'd200);
		foreach (body[i])
			send_pixel(body[i]);
		drain_pipeline();
		write_reg(blmd_pkg::REG_IMAGE_HEIGHT, 11'd3);
		repeat (4) send_pixel(PIX_W'($urandom_range(0, 255)));
	endtask

	// Smallest frame, sizes below range, darkest centre among brightest neighbours.
	task automatic test_extreme_levels();
		finish_frame();
		drain_pipeline();
		write_reg(blmd_pkg::REG_IMAGE_WIDTH, 11'd2);
		write_reg(blmd_pkg::REG_IMAGE_HEIGHT, 11'd0);
		for (int k = 0; k < 9; k++)
			send_pixel((k == 4) ? 8'd0 : 8'd255);
	endtask

	task automatic test_random_frames(input int unsigned item_budget);
		int unsigned      sent, seg_len, to_end, cur_w;
		level_mode_t      mode;
		logic [PIX_W-1:0] base;
		sent = 0;
		while (sent < item_budget) begin
			no_idle = ($urandom_range(0, 5) == 0);
			if (sent == 0 || $urandom_range(0, 2) != 0) begin
				drain_pipeline();
				// only shrink the width mid-frame so no window sees an unwritten column
				if (col_at == 0 && row_at == 0) begin
					write_reg(blmd_pkg::REG_IMAGE_WIDTH, pick_side());
				end else begin
					cur_w = clamp_side(width_reg, MAX_WIDTH_DEF);
					if ($urandom_range(0, 5) == 0)
						write_reg(blmd_pkg::REG_IMAGE_WIDTH,
							CFG_W'($urandom_range(0, 2)));
					else
						write_reg(blmd_pkg::REG_IMAGE_WIDTH,
							CFG_W'($urandom_range(SIDE_MIN, cur_w)));
				end
				if ($urandom_range(0, 1) != 0)
					write_reg(blmd_pkg::REG_IMAGE_HEIGHT, pick_side());
			end
			to_end = frame_remaining();
			seg_len = ($urandom_range(0, 3) != 0) ? to_end : $urandom_range(1, to_end);
			if (seg_len > item_budget - sent)
				seg_len = item_budget - sent;
			mode = level_mode_t'($urandom_range(0, 2));
			base = PIX_W'($urandom_range(0, 253));
			repeat (seg_len) send_pixel(random_level(mode, base));
			sent += seg_len;
		end
		no_idle = 1'b0;
	endtask

	// Receiver side: random stalls, mostly short.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			res.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			res.ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 3) == 0)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin : check_minima
		min_pos_t want;
		if (arst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
			if (expected_minima.size() == 0) begin
				$display("%0t: unexpected result, expected none, got row %0d col %0d",
					$time, res.min_row, res.min_col);
				error_count++;
			end else begin
				want = expected_minima.pop_front();
				if (res.min_row !== want.row) begin
					$display("%0t: min_row mismatch, expected %0d, got %0d",
						$time, want.row, res.min_row);
					error_count++;
				end
				if (res.min_col !== want.col) begin
					$display("%0t: min_col mismatch, expected %0d, got %0d",
						$time, want.col, res.min_col);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pix.valid === 1'b1 && pix.ready === 1'b1) ||
				(res.valid === 1'b1 && res.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = blmd_pkg::REG_IMAGE_WIDTH;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.blue_sample = '0;
		res.ready = 1'b0;
		reset_window_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_extreme_levels();
		test_random_frames(RANDOM_ITEMS);

		drain_pipeline();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
